// ===== hw/rtl/ypc_pkg.sv =====
`timescale 1ns / 1ps

package ypc_pkg;

  localparam int ANGLE_W = 15;   // yaw in 1/64 degree
  localparam int PITCH_W = 14;   // pitch in 1/64 degree
  localparam int DELTA_W = 15;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = 25;   // target minus position
  localparam int NORM_W  = 30;   // normalized vector lanes
  localparam int COR_W   = 34;   // CORDIC datapath
  localparam int PROD_W  = 68;   // shared multiplier product
  localparam int TRIG_W  = 32;   // Q30 sine and cosine
  localparam int VEC_W   = 16;   // Q1.14 outputs
  localparam int OP_W    = 2;
  localparam int IDX_W   = 2;
  localparam int STEPS   = 16;
  localparam int STEP_W  = 4;
  localparam int NUM_VEC = 8;

  localparam logic [OP_W-1:0] OP_YAW   = 2'd0;
  localparam logic [OP_W-1:0] OP_PITCH = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOK  = 2'd2;

  localparam logic [IDX_W-1:0] REG_POS_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_POS_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_POS_Z = 2'd2;

  localparam logic signed [COR_W-1:0] INV_GAIN  = 34'sd652032874;
  localparam logic signed [COR_W-1:0] HALF_TURN = 34'sd2147483648;
  localparam logic signed [COR_W-1:0] TRIG_ONE  = 34'sd1073741824;

  typedef struct packed {
    logic signed [COR_W-1:0] x;
    logic signed [COR_W-1:0] y;
    logic signed [COR_W-1:0] z;
  } cor_vec_t;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic signed [COR_W-1:0] atan_bam(input logic [STEP_W-1:0] i);
    logic signed [COR_W-1:0] a;
    case (i)
      4'd0:    a = 34'sd536870912;
      4'd1:    a = 34'sd316933406;
      4'd2:    a = 34'sd167458907;
      4'd3:    a = 34'sd85004756;
      4'd4:    a = 34'sd42667331;
      4'd5:    a = 34'sd21354465;
      4'd6:    a = 34'sd10679838;
      4'd7:    a = 34'sd5340245;
      4'd8:    a = 34'sd2670163;
      4'd9:    a = 34'sd1335087;
      4'd10:   a = 34'sd667544;
      4'd11:   a = 34'sd333772;
      4'd12:   a = 34'sd166886;
      4'd13:   a = 34'sd83443;
      4'd14:   a = 34'sd41722;
      4'd15:   a = 34'sd20861;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // binary angle of r/45 of a 2^23 unit, rounded as the angle conversion needs
  function automatic logic [22:0] frac_bam(input logic [5:0] r);
    logic [31:0] t;
    t = 32'(r) * 32'd186413 + ((32'(r) + 32'd1) >> 1);
    return t[22:0];
  endfunction

endpackage

// ===== hw/rtl/ypc_if.sv =====
`timescale 1ns / 1ps

interface ypc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [ypc_pkg::OP_W-1:0]        operation;
  logic signed [ypc_pkg::DELTA_W-1:0]     delta_angle;
  logic signed [ypc_pkg::COORD_W-1:0]     target_x;
  logic signed [ypc_pkg::COORD_W-1:0]     target_y;
  logic signed [ypc_pkg::COORD_W-1:0]     target_z;

  modport source (output valid, operation, delta_angle, target_x, target_y, target_z,
                  input ready);
  modport sink   (input valid, operation, delta_angle, target_x, target_y, target_z,
                  output ready);
endinterface

interface ypc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ypc_pkg::VEC_W-1:0]       forward_x;
  logic signed [ypc_pkg::VEC_W-1:0]       forward_y;
  logic signed [ypc_pkg::VEC_W-1:0]       forward_z;
  logic signed [ypc_pkg::VEC_W-1:0]       right_x;
  logic signed [ypc_pkg::VEC_W-1:0]       right_z;
  logic signed [ypc_pkg::VEC_W-1:0]       up_x;
  logic signed [ypc_pkg::VEC_W-1:0]       up_y;
  logic signed [ypc_pkg::VEC_W-1:0]       up_z;
  logic signed [ypc_pkg::ANGLE_W-1:0]     yaw_now;
  logic signed [ypc_pkg::PITCH_W-1:0]     pitch_now;
  logic                                   aim_degenerate;

  modport source (output valid, forward_x, forward_y, forward_z, right_x, right_z,
                  up_x, up_y, up_z, yaw_now, pitch_now, aim_degenerate,
                  input ready);
  modport sink   (input valid, forward_x, forward_y, forward_z, right_x, right_z,
                  up_x, up_y, up_z, yaw_now, pitch_now, aim_degenerate,
                  output ready);
endinterface

// ===== hw/rtl/yaw_pitch_camera_orientation.sv =====
`timescale 1ns / 1ps

// Camera orientation from yaw and pitch. Each request either adds a delta to
// yaw (wrapped once into [-180,180) degrees), adds a delta to pitch (clamped
// to +-80 degrees) or aims at a target relative to the position registers;
// every request returns one result with the forward, right and up unit
// vectors in Q1.14 and the angles in 1/64 degree. All trigonometry runs on
// one CORDIC stage that iterates 16 steps per pass, next to one shared
// 34x34 multiplier and a one-bit-per-cycle normalizing shifter. A yaw,
// pitch or unused request runs two 16-step rotation passes, each after an
// angle multiply/round slot, then eight multiply/round slots. A look-at
// that is not straight up, straight down or degenerate first adds two
// normalizing shifts and three 16-step vectoring passes. in_ch.ready
// is high only while the sequencer is idle; a finished result sits in the
// output register, so the next request is taken while it waits.
module yaw_pitch_camera_orientation (
  input  logic                                clk,
  input  logic                                rst_n,
  ypc_in_if.sink                              in_ch,
  ypc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic        [ypc_pkg::IDX_W-1:0]    cfg_index,
  input  logic signed [ypc_pkg::COORD_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_NORM_H, S_VEC_H, S_YAW_MUL, S_YAW_FIN, S_NORM_P, S_VEC_HK,
    S_HK_MUL, S_HK_FIN, S_VEC_P, S_P_MUL, S_P_FIN, S_TH_MUL, S_TH_FIN,
    S_ROT, S_SC_FIN, S_OUT_MUL, S_OUT_FIN, S_DONE
  } state_t;

  localparam logic signed [17:0] HALF_DEG  = 18'sd11520;
  localparam logic signed [17:0] FULL_DEG  = 18'sd23040;
  localparam logic signed [17:0] VERT_DEG  = 18'sd5760;
  localparam logic signed [17:0] PLIM_DEG  = 18'sd5120;
  localparam logic signed [ypc_pkg::COR_W-1:0] DEG_SCALE = 34'sd23040;
  localparam logic signed [ypc_pkg::COR_W-1:0] RECIP_45  = 34'sd46604;
  localparam logic signed [15:0] ANG_OFS   = 16'sd16380;   // 45 * 364
  localparam logic signed [10:0] QUO_OFS   = 11'sd364;
  localparam logic signed [ypc_pkg::NORM_W-1:0] NORM_LIM = 30'sd268435456;
  localparam logic signed [ypc_pkg::PROD_W-1:0] RND30 = 68'sd536870912;
  localparam logic signed [ypc_pkg::PROD_W-1:0] RND32 = 68'sd2147483648;
  localparam logic signed [ypc_pkg::PROD_W-1:0] RND46 = 68'sd35184372088832;
  localparam logic signed [ypc_pkg::PROD_W-1:0] VEC_ONE = 68'sd16384;
  localparam logic [ypc_pkg::STEP_W-1:0] LAST_STEP = ypc_pkg::STEP_W'(ypc_pkg::STEPS - 1);
  localparam logic [2:0] LAST_VEC = 3'(ypc_pkg::NUM_VEC - 1);

  state_t state_r, state_nxt;

  // angles and configuration
  logic signed [ypc_pkg::ANGLE_W-1:0] yaw_r, yaw_nxt;
  logic signed [ypc_pkg::PITCH_W-1:0] pitch_r, pitch_nxt;
  logic signed [ypc_pkg::COORD_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [ypc_pkg::COORD_W-1:0] pos_z_r, pos_z_nxt;

  // look-at working set
  logic signed [ypc_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic signed [ypc_pkg::NORM_W-1:0] n0_r, n0_nxt, n1_r, n1_nxt, n2_r, n2_nxt;

  // CORDIC stage
  ypc_pkg::cor_vec_t cor_r, cor_nxt, cor_step;
  logic [ypc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic sel_r, sel_nxt, flip_r, flip_nxt;

  // shared multiplier
  logic signed [ypc_pkg::COR_W-1:0]  mul_a, mul_b;
  logic signed [ypc_pkg::PROD_W-1:0] mul_p, prod_r;

  // sine and cosine, Q30
  logic signed [ypc_pkg::TRIG_W-1:0] cos_y_r, cos_y_nxt, sin_y_r, sin_y_nxt;
  logic signed [ypc_pkg::TRIG_W-1:0] cos_p_r, cos_p_nxt, sin_p_r, sin_p_nxt;

  // result build-up and output register
  logic [2:0] vk_r, vk_nxt;
  logic signed [ypc_pkg::VEC_W-1:0] res_vec_r [ypc_pkg::NUM_VEC];
  logic signed [ypc_pkg::VEC_W-1:0] res_vec_nxt [ypc_pkg::NUM_VEC];
  logic degen_r, degen_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [ypc_pkg::VEC_W-1:0] out_vec_r [ypc_pkg::NUM_VEC];
  logic signed [ypc_pkg::VEC_W-1:0] out_vec_nxt [ypc_pkg::NUM_VEC];
  logic signed [ypc_pkg::ANGLE_W-1:0] out_yaw_r, out_yaw_nxt;
  logic signed [ypc_pkg::PITCH_W-1:0] out_pitch_r, out_pitch_nxt;
  logic out_degen_r, out_degen_nxt;

  logic in_fire;

  // Load a vectoring pass: fold the left half plane onto the right.
  function automatic ypc_pkg::cor_vec_t vec_load(input logic signed [ypc_pkg::COR_W-1:0] x,
                                                 input logic signed [ypc_pkg::COR_W-1:0] y);
    ypc_pkg::cor_vec_t v;
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y >= 0) ? ypc_pkg::HALF_TURN : -ypc_pkg::HALF_TURN;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic logic is_small(input logic signed [ypc_pkg::NORM_W-1:0] v);
    return (v < NORM_LIM) && (v > -NORM_LIM);
  endfunction

  function automatic logic signed [ypc_pkg::TRIG_W-1:0] trig_clamp(
      input logic signed [ypc_pkg::COR_W-1:0] v, input logic neg);
    logic signed [ypc_pkg::COR_W-1:0] c;
    c = v;
    if (v > ypc_pkg::TRIG_ONE) c = ypc_pkg::TRIG_ONE;
    else if (v < -ypc_pkg::TRIG_ONE) c = -ypc_pkg::TRIG_ONE;
    if (neg) c = -c;
    return ypc_pkg::TRIG_W'(c);
  endfunction

  // Binary angle to 1/64 degree, rounded half up.
  function automatic logic signed [17:0] bam_deg(input logic signed [ypc_pkg::PROD_W-1:0] p);
    logic signed [ypc_pkg::PROD_W-1:0] s;
    s = (p + RND32) >>> 32;
    return s[17:0];
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign mul_p        = ypc_pkg::PROD_W'(mul_a) * ypc_pkg::PROD_W'(mul_b);

  // One CORDIC micro-rotation: vectoring drives y to zero, rotation drives z.
  always_comb begin
    logic signed [ypc_pkg::COR_W-1:0] xs, ys, at;
    logic sigma;
    xs = cor_r.x >>> step_r;
    ys = cor_r.y >>> step_r;
    at = ypc_pkg::atan_bam(step_r);
    sigma = (state_r == S_ROT) ? !cor_r.z[ypc_pkg::COR_W-1] : cor_r.y[ypc_pkg::COR_W-1];
    if (sigma) begin
      cor_step.x = cor_r.x - ys;
      cor_step.y = cor_r.y + xs;
      cor_step.z = cor_r.z - at;
    end else begin
      cor_step.x = cor_r.x + ys;
      cor_step.y = cor_r.y - xs;
      cor_step.z = cor_r.z + at;
    end
  end

  // Multiplier operand select.
  always_comb begin
    logic signed [ypc_pkg::ANGLE_W-1:0] ang;
    ang = sel_r ? ypc_pkg::ANGLE_W'(pitch_r) : yaw_r;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_YAW_MUL, S_P_MUL: begin
        mul_a = cor_r.z;
        mul_b = DEG_SCALE;
      end
      S_HK_MUL: begin
        mul_a = cor_r.x;
        mul_b = ypc_pkg::INV_GAIN;
      end
      S_TH_MUL: begin
        mul_a = ypc_pkg::COR_W'(16'(ang) + ANG_OFS);
        mul_b = RECIP_45;
      end
      S_OUT_MUL: begin
        case (vk_r)
          3'd0: begin mul_a = -ypc_pkg::COR_W'(sin_y_r); mul_b = ypc_pkg::COR_W'(cos_p_r); end
          3'd1: begin mul_a = ypc_pkg::COR_W'(sin_p_r);  mul_b = ypc_pkg::TRIG_ONE; end
          3'd2: begin mul_a = -ypc_pkg::COR_W'(cos_y_r); mul_b = ypc_pkg::COR_W'(cos_p_r); end
          3'd3: begin mul_a = ypc_pkg::COR_W'(cos_y_r);  mul_b = ypc_pkg::TRIG_ONE; end
          3'd4: begin mul_a = -ypc_pkg::COR_W'(sin_y_r); mul_b = ypc_pkg::TRIG_ONE; end
          3'd5: begin mul_a = ypc_pkg::COR_W'(sin_y_r);  mul_b = ypc_pkg::COR_W'(sin_p_r); end
          3'd6: begin mul_a = ypc_pkg::COR_W'(cos_p_r);  mul_b = ypc_pkg::TRIG_ONE; end
          default: begin
            mul_a = ypc_pkg::COR_W'(cos_y_r);
            mul_b = ypc_pkg::COR_W'(sin_p_r);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    logic signed [16:0] ysum;
    logic signed [15:0] psum;
    logic signed [ypc_pkg::DIFF_W-1:0] dxw, dyw, dzw;
    logic signed [17:0] deg;
    logic signed [ypc_pkg::PROD_W-1:0] rnd;
    logic signed [ypc_pkg::ANGLE_W-1:0] ang;
    logic [15:0] ap, ra16;
    logic [9:0] qap;
    logic signed [10:0] qa;
    logic [31:0] th;
    logic fl;

    state_nxt   = state_r;
    yaw_nxt     = yaw_r;
    pitch_nxt   = pitch_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    pos_z_nxt   = pos_z_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    dz_nxt      = dz_r;
    n0_nxt      = n0_r;
    n1_nxt      = n1_r;
    n2_nxt      = n2_r;
    cor_nxt     = cor_r;
    step_nxt    = step_r;
    sel_nxt     = sel_r;
    flip_nxt    = flip_r;
    cos_y_nxt   = cos_y_r;
    sin_y_nxt   = sin_y_r;
    cos_p_nxt   = cos_p_r;
    sin_p_nxt   = sin_p_r;
    vk_nxt      = vk_r;
    res_vec_nxt = res_vec_r;
    degen_nxt   = degen_r;
    out_vec_nxt   = out_vec_r;
    out_yaw_nxt   = out_yaw_r;
    out_pitch_nxt = out_pitch_r;
    out_degen_nxt = out_degen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    ysum = '0;
    psum = '0;
    dxw  = ypc_pkg::DIFF_W'(in_ch.target_x) - ypc_pkg::DIFF_W'(pos_x_r);
    dyw  = ypc_pkg::DIFF_W'(in_ch.target_y) - ypc_pkg::DIFF_W'(pos_y_r);
    dzw  = ypc_pkg::DIFF_W'(in_ch.target_z) - ypc_pkg::DIFF_W'(pos_z_r);
    deg  = '0;
    rnd  = '0;
    ang  = sel_r ? ypc_pkg::ANGLE_W'(pitch_r) : yaw_r;
    ap   = 16'(16'(ang) + ANG_OFS);
    qap  = prod_r[30:21];
    ra16 = ap - 16'(qap) * 16'd45;
    qa   = $signed({1'b0, qap}) - QUO_OFS;
    th   = {qa[8:0], 23'b0} + {9'b0, ypc_pkg::frac_bam(ra16[5:0])};
    fl   = 1'b0;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        ypc_pkg::REG_POS_X: pos_x_nxt = cfg_data;
        ypc_pkg::REG_POS_Y: pos_y_nxt = cfg_data;
        ypc_pkg::REG_POS_Z: pos_z_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          degen_nxt = 1'b0;
          sel_nxt   = 1'b0;
          state_nxt = S_TH_MUL;
          case (in_ch.operation)
            ypc_pkg::OP_YAW: begin
              ysum = 17'(yaw_r) + 17'(in_ch.delta_angle);
              if (ysum >= 17'(HALF_DEG)) ysum = ysum - 17'(FULL_DEG);
              else if (ysum < -17'(HALF_DEG)) ysum = ysum + 17'(FULL_DEG);
              yaw_nxt = ysum[ypc_pkg::ANGLE_W-1:0];
            end
            ypc_pkg::OP_PITCH: begin
              psum = 16'(pitch_r) + 16'(in_ch.delta_angle);
              if (psum > 16'(PLIM_DEG)) psum = 16'(PLIM_DEG);
              else if (psum < -16'(PLIM_DEG)) psum = -16'(PLIM_DEG);
              pitch_nxt = psum[ypc_pkg::PITCH_W-1:0];
            end
            ypc_pkg::OP_LOOK: begin
              dx_nxt = dxw;
              dy_nxt = dyw;
              dz_nxt = dzw;
              if (dxw == 0 && dyw == 0 && dzw == 0) begin
                degen_nxt = 1'b1;
              end else if (dxw == 0 && dzw == 0) begin
                // straight up or down
                yaw_nxt   = -ypc_pkg::ANGLE_W'(HALF_DEG);
                pitch_nxt = (dyw > 0) ? ypc_pkg::PITCH_W'(VERT_DEG)
                                      : -ypc_pkg::PITCH_W'(VERT_DEG);
              end else begin
                n0_nxt    = -ypc_pkg::NORM_W'(dzw);
                n1_nxt    = ypc_pkg::NORM_W'(dxw);
                n2_nxt    = '0;
                state_nxt = S_NORM_H;
              end
            end
            default: ;
          endcase
        end
      end
      S_NORM_H, S_NORM_P: begin
        if (is_small(n0_r) && is_small(n1_r) && is_small(n2_r)) begin
          n0_nxt = n0_r <<< 1;
          n1_nxt = n1_r <<< 1;
          n2_nxt = n2_r <<< 1;
        end else begin
          step_nxt = '0;
          if (state_r == S_NORM_H) begin
            cor_nxt   = vec_load(ypc_pkg::COR_W'(n0_r), ypc_pkg::COR_W'(n1_r));
            state_nxt = S_VEC_H;
          end else begin
            cor_nxt   = vec_load(-ypc_pkg::COR_W'(n2_r), ypc_pkg::COR_W'(n0_r));
            state_nxt = S_VEC_HK;
          end
        end
      end
      S_VEC_H, S_VEC_HK, S_VEC_P, S_ROT: begin
        cor_nxt  = cor_step;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          case (state_r)
            S_VEC_H:  state_nxt = S_YAW_MUL;
            S_VEC_HK: state_nxt = S_HK_MUL;
            S_VEC_P:  state_nxt = S_P_MUL;
            default:  state_nxt = S_SC_FIN;
          endcase
        end
      end
      S_YAW_MUL: state_nxt = S_YAW_FIN;
      S_YAW_FIN: begin
        deg = -bam_deg(prod_r);
        if (deg >= HALF_DEG) deg = deg - FULL_DEG;
        else if (deg < -HALF_DEG) deg = deg + FULL_DEG;
        yaw_nxt   = deg[ypc_pkg::ANGLE_W-1:0];
        n0_nxt    = ypc_pkg::NORM_W'(dx_r);
        n1_nxt    = ypc_pkg::NORM_W'(dy_r);
        n2_nxt    = ypc_pkg::NORM_W'(dz_r);
        state_nxt = S_NORM_P;
      end
      S_HK_MUL: state_nxt = S_HK_FIN;
      S_HK_FIN: begin
        // horizontal length with the CORDIC gain taken out
        rnd       = (prod_r + RND30) >>> 30;
        cor_nxt   = vec_load(rnd[ypc_pkg::COR_W-1:0], ypc_pkg::COR_W'(n1_r));
        step_nxt  = '0;
        state_nxt = S_VEC_P;
      end
      S_P_MUL: state_nxt = S_P_FIN;
      S_P_FIN: begin
        deg = bam_deg(prod_r);
        if (deg > VERT_DEG) deg = VERT_DEG;
        else if (deg < -VERT_DEG) deg = -VERT_DEG;
        pitch_nxt = deg[ypc_pkg::PITCH_W-1:0];
        sel_nxt   = 1'b0;
        state_nxt = S_TH_MUL;
      end
      S_TH_MUL: state_nxt = S_TH_FIN;
      S_TH_FIN: begin
        // fold the left half turn onto the right and negate at the end
        if (th >= 32'h4000_0000 && th < 32'hC000_0000) begin
          th = th - 32'h8000_0000;
          fl = 1'b1;
        end
        cor_nxt.x = ypc_pkg::INV_GAIN;
        cor_nxt.y = '0;
        cor_nxt.z = ypc_pkg::COR_W'($signed(th));
        flip_nxt  = fl;
        step_nxt  = '0;
        state_nxt = S_ROT;
      end
      S_SC_FIN: begin
        if (!sel_r) begin
          cos_y_nxt = trig_clamp(cor_r.x, flip_r);
          sin_y_nxt = trig_clamp(cor_r.y, flip_r);
          sel_nxt   = 1'b1;
          state_nxt = S_TH_MUL;
        end else begin
          cos_p_nxt = trig_clamp(cor_r.x, flip_r);
          sin_p_nxt = trig_clamp(cor_r.y, flip_r);
          vk_nxt    = '0;
          state_nxt = S_OUT_MUL;
        end
      end
      S_OUT_MUL: state_nxt = S_OUT_FIN;
      S_OUT_FIN: begin
        rnd = (prod_r + RND46) >>> 46;
        if (rnd > VEC_ONE) rnd = VEC_ONE;
        else if (rnd < -VEC_ONE) rnd = -VEC_ONE;
        res_vec_nxt[vk_r] = rnd[ypc_pkg::VEC_W-1:0];
        if (vk_r == LAST_VEC) begin
          state_nxt = S_DONE;
        end else begin
          vk_nxt    = vk_r + 1'b1;
          state_nxt = S_OUT_MUL;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_vec_nxt   = res_vec_r;
          out_yaw_nxt   = yaw_r;
          out_pitch_nxt = pitch_r;
          out_degen_nxt = degen_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      yaw_r       <= '0;
      pitch_r     <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      yaw_r       <= yaw_nxt;
      pitch_r     <= pitch_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dz_r        <= dz_nxt;
    n0_r        <= n0_nxt;
    n1_r        <= n1_nxt;
    n2_r        <= n2_nxt;
    cor_r       <= cor_nxt;
    step_r      <= step_nxt;
    sel_r       <= sel_nxt;
    flip_r      <= flip_nxt;
    prod_r      <= mul_p;
    cos_y_r     <= cos_y_nxt;
    sin_y_r     <= sin_y_nxt;
    cos_p_r     <= cos_p_nxt;
    sin_p_r     <= sin_p_nxt;
    vk_r        <= vk_nxt;
    res_vec_r   <= res_vec_nxt;
    degen_r     <= degen_nxt;
    out_vec_r   <= out_vec_nxt;
    out_yaw_r   <= out_yaw_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_degen_r <= out_degen_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.forward_x      = out_vec_r[0];
  assign out_ch.forward_y      = out_vec_r[1];
  assign out_ch.forward_z      = out_vec_r[2];
  assign out_ch.right_x        = out_vec_r[3];
  assign out_ch.right_z        = out_vec_r[4];
  assign out_ch.up_x           = out_vec_r[5];
  assign out_ch.up_y           = out_vec_r[6];
  assign out_ch.up_z           = out_vec_r[7];
  assign out_ch.yaw_now        = out_yaw_r;
  assign out_ch.pitch_now      = out_pitch_r;
  assign out_ch.aim_degenerate = out_degen_r;

endmodule

// ===== hw/rtl/ypc_checker.sv =====
`timescale 1ns / 1ps

module ypc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ypc_pkg::ANGLE_W-1:0]  out_yaw,
  input logic signed [ypc_pkg::PITCH_W-1:0]  out_pitch
);

  // one request at a time: drop ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accept");

  // a result is posted only as the sequencer goes back to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while the sequencer is busy");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch <= 14'sd5760 && out_pitch >= -14'sd5760 &&
                  out_yaw <= 15'sd11519 && out_yaw >= -15'sd11520)
    else $error("angle out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw) && $stable(out_pitch))
    else $error("stalled result changed");

endmodule

bind yaw_pitch_camera_orientation ypc_checker u_ypc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_yaw   (out_ch.yaw_now),
  .out_pitch (out_ch.pitch_now)
);
